/* design/i2cdac_pkg.sv */
`default_nettype none

package i2cdac_pkg;

  // Widths
  localparam int TIMER_WIDTH = 16;
  localparam int LEVEL_BITS  = 12;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  // Register reset values
  localparam logic [TIMER_WIDTH-1:0] DELAY_RST   = TIMER_WIDTH'(100);
  localparam logic [TIMER_WIDTH-1:0] TIMEOUT_RST = TIMER_WIDTH'(100);
  localparam logic [7:0]             DEVADDR_RST = 8'h90;
  localparam logic [7:0]             DACCMD_RST  = 8'h2f;

  // Register indexes (paddr word address)
  typedef enum logic [1:0] {
    REG_DELAY   = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_DEVADDR = 2'd2,
    REG_DACCMD  = 2'd3
  } reg_idx_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_RDY  = 2'd1,
    ST_ADDR_NAK = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  // Byte slots of one transfer
  typedef enum logic [1:0] {
    BYTE_ADDR = 2'd0,
    BYTE_CMD  = 2'd1,
    BYTE_HI   = 2'd2,
    BYTE_LO   = 2'd3
  } byte_idx_t;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_WAIT      = 4'd1,
    PH_START     = 4'd2,
    PH_BIT_LOW   = 4'd3,
    PH_BIT_HIGH  = 4'd4,
    PH_ACK_LOW   = 4'd5,
    PH_ACK_HIGH  = 4'd6,
    PH_ACK_TAIL  = 4'd7,
    PH_STOP_LOW  = 4'd8,
    PH_STOP_HIGH = 4'd9,
    PH_STOP_TAIL = 4'd10
  } phase_t;

  typedef struct packed {
    logic                  command;
    logic [LEVEL_BITS-1:0] level;
    logic                  sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_high;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

endpackage

`default_nettype wire

/* design/i2c_dac_level_writer_unit.sv */
`default_nettype none

// Channel   Direction  Handshake          Payload
// in        to unit    in_valid/in_stall   in_data  (command, level, sda_in)
// out       from unit  out_valid/out_stall out_data (scl, sda, busy, done, status)
// cfg       to unit    APB write/read      delay, timeout, address, command
//
// One transaction in gives one transaction out; the sequencer steps once per
// accepted item, so an item can be taken every cycle while in_stall is low.
// Results sit in an output register backed by one skid register; in_stall
// rises only while both are full.
// Synchronous active-high reset returns the sequencer to idle with SCL
// released and the registers to their defaults.

module i2c_dac_level_writer_unit
  import i2cdac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire in_item_t          in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      out_item_t         out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready
);

  // Configuration registers
  logic [TIMER_WIDTH-1:0] delay_ticks;
  logic [TIMER_WIDTH-1:0] ready_timeout;
  logic [7:0]             device_address;
  logic [7:0]             dac_command;
  reg_idx_t               cfg_idx;
  logic                   cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks    <= DELAY_RST;
      ready_timeout  <= TIMEOUT_RST;
      device_address <= DEVADDR_RST;
      dac_command    <= DACCMD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DELAY:   delay_ticks    <= pwdata[TIMER_WIDTH-1:0];
        REG_TIMEOUT: ready_timeout  <= pwdata[TIMER_WIDTH-1:0];
        REG_DEVADDR: device_address <= pwdata[7:0];
        REG_DACCMD:  dac_command    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (cfg_idx)
      REG_DELAY:   prdata = APB_DW'(delay_ticks);
      REG_TIMEOUT: prdata = APB_DW'(ready_timeout);
      REG_DEVADDR: prdata = APB_DW'(device_address);
      REG_DACCMD:  prdata = APB_DW'(dac_command);
      default:     prdata = '0;
    endcase
  end

  // Sequencer state
  phase_t                 phase, phase_next;
  logic [TIMER_WIDTH-1:0] tick_count, tick_count_next;
  logic [3:0]             bit_count, bit_count_next;
  logic [1:0]             byte_index, byte_index_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [LEVEL_BITS-1:0]  level_latch, level_latch_next;
  logic                   scl_state, scl_state_next;
  logic                   sda_state, sda_state_next;
  status_t                last_status, last_status_next;
  logic                   done;
  logic                   accept;
  logic                   tick_last;
  logic [3:0]             bit_inc;
  logic [7:0]             shift_up;
  logic [1:0]             load_idx;
  logic [7:0]             load_byte;
  out_item_t              result;

  assign tick_last = (tick_count <= TIMER_WIDTH'(1));
  assign bit_inc   = bit_count + 4'd1;
  assign shift_up  = {shift_byte[6:0], 1'b0};
  // Next byte slot: restart at address from START, else advance
  assign load_idx  = (phase == PH_START) ? 2'(BYTE_ADDR) : byte_index + 2'd1;

  // Byte selection for the slot being loaded
  always_comb begin
    case (byte_idx_t'(load_idx))
      BYTE_ADDR: load_byte = device_address;
      BYTE_CMD:  load_byte = dac_command;
      BYTE_HI:   load_byte = level_latch[11:4];
      BYTE_LO:   load_byte = {level_latch[3:0], 4'b0000};
      default:   load_byte = '0;
    endcase
  end

  // One tick of the bus sequencer
  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_count_next   = bit_count;
    byte_index_next  = byte_index;
    shift_byte_next  = shift_byte;
    level_latch_next = level_latch;
    scl_state_next   = scl_state;
    sda_state_next   = sda_state;
    last_status_next = last_status;
    done             = 1'b0;

    if (phase == PH_IDLE) begin
      if (in_data.command) begin
        level_latch_next = in_data.level;
        scl_state_next   = 1'b1;
        last_status_next = ST_OK;
        byte_index_next  = 2'(BYTE_ADDR);
        tick_count_next  = ready_timeout;
        phase_next       = PH_WAIT;
      end
    end else if (phase == PH_WAIT) begin
      if (in_data.sda_in) begin
        sda_state_next  = 1'b1;
        tick_count_next = delay_ticks;
        phase_next      = PH_START;
      end else if (tick_last) begin
        last_status_next = ST_NOT_RDY;
        done             = 1'b1;
        phase_next       = PH_IDLE;
      end else begin
        tick_count_next = tick_count - TIMER_WIDTH'(1);
      end
    end else if (!tick_last) begin
      tick_count_next = tick_count - TIMER_WIDTH'(1);
    end else begin
      tick_count_next = delay_ticks;
      case (phase)
        PH_START: begin
          scl_state_next  = 1'b0;
          byte_index_next = load_idx;
          shift_byte_next = load_byte;
          bit_count_next  = '0;
          sda_state_next  = ~load_byte[7];
          phase_next      = PH_BIT_LOW;
        end
        PH_BIT_LOW: begin
          scl_state_next = 1'b1;
          phase_next     = PH_BIT_HIGH;
        end
        PH_BIT_HIGH: begin
          scl_state_next  = 1'b0;
          shift_byte_next = shift_up;
          bit_count_next  = bit_inc;
          if (bit_inc < 4'd8) begin
            sda_state_next = ~shift_up[7];
            phase_next     = PH_BIT_LOW;
          end else begin
            sda_state_next = 1'b0;
            phase_next     = PH_ACK_LOW;
          end
        end
        PH_ACK_LOW: begin
          scl_state_next = 1'b1;
          phase_next     = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          // Only the address byte's ack is checked
          if (byte_index == 2'(BYTE_ADDR) && in_data.sda_in) begin
            last_status_next = ST_ADDR_NAK;
          end
          phase_next = PH_ACK_TAIL;
        end
        PH_ACK_TAIL: begin
          scl_state_next = 1'b0;
          if (byte_index != 2'(BYTE_LO)) begin
            byte_index_next = load_idx;
            shift_byte_next = load_byte;
            bit_count_next  = '0;
            sda_state_next  = ~load_byte[7];
            phase_next      = PH_BIT_LOW;
          end else begin
            sda_state_next = 1'b1;
            phase_next     = PH_STOP_LOW;
          end
        end
        PH_STOP_LOW: begin
          scl_state_next = 1'b1;
          phase_next     = PH_STOP_HIGH;
        end
        PH_STOP_HIGH: begin
          sda_state_next = 1'b0;
          phase_next     = PH_STOP_TAIL;
        end
        default: begin
          done       = 1'b1;
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  assign result = '{scl_high: scl_state_next,
                    sda_low:  sda_state_next,
                    busy_res: (phase_next != PH_IDLE),
                    done_res: done,
                    status:   last_status_next};

  assign accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      bit_count   <= '0;
      byte_index  <= '0;
      shift_byte  <= '0;
      level_latch <= '0;
      scl_state   <= 1'b1;
      sda_state   <= 1'b0;
      last_status <= ST_OK;
    end else if (accept) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_count   <= bit_count_next;
      byte_index  <= byte_index_next;
      shift_byte  <= shift_byte_next;
      level_latch <= level_latch_next;
      scl_state   <= scl_state_next;
      sda_state   <= sda_state_next;
      last_status <= last_status_next;
    end
  end

  // Output register with one skid entry
  out_item_t skid_data;
  logic      skid_valid;
  logic      pop;

  assign pop      = out_valid & ~out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

endmodule

`default_nettype wire

/* design/i2cdac_checker.sv */
`default_nettype none

module i2cdac_checker
  import i2cdac_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A transfer that ends is no longer busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.busy_res)
    else $error("done reported while still busy");

  // Input back-pressure only when a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Every accepted transaction leaves a result on the output
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  // Reserved status code never shown
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status != ST_RSVD))
    else $error("reserved status code on output");

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("result pending after reset");

endmodule

bind i2c_dac_level_writer_unit i2cdac_checker u_i2cdac_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
